[hdl/tbwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwd_pkg
// shared constants and status codes of the two-word by one-word divider
// ----------------------------------------------------------------------------
package tbwd_pkg;

  localparam int unsigned WordWidth = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

endpackage

[hdl/tbwd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwd_cell
// one restoring division step with its own output register and stall logic
// ----------------------------------------------------------------------------
module tbwd_cell #(
  parameter int unsigned Width = tbwd_pkg::WordWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [Width-1:0]   rem_i,
  input  logic [Width-1:0]   low_i,
  input  logic [Width-1:0]   div_i,
  input  logic [Width-1:0]   quo_i,
  input  tbwd_pkg::status_e  status_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [Width-1:0]   rem_o,
  output logic [Width-1:0]   low_o,
  output logic [Width-1:0]   div_o,
  output logic [Width-1:0]   quo_o,
  output tbwd_pkg::status_e  status_o
);
  import tbwd_pkg::*;

  logic             valid_q;
  logic [Width-1:0] rem_d, rem_q;
  logic [Width-1:0] low_d, low_q;
  logic [Width-1:0] div_q;
  logic [Width-1:0] quo_d, quo_q;
  status_e          status_q;
  logic [Width-1:0] dbl;
  logic [Width:0]   diff;
  logic             take;

  // the cell moves on whenever its register is empty or drains this cycle
  assign stall_o = valid_q & stall_i;

  always_comb begin
    dbl  = {rem_i[Width-2:0], low_i[Width-1]};
    diff = {1'b0, dbl} - {1'b0, div_i};
    // a set top bit means the true doubled value exceeds any one-word divisor
    take = rem_i[Width-1] | ~diff[Width];
    rem_d = take ? diff[Width-1:0] : dbl;
    quo_d = {quo_i[Width-2:0], take};
    low_d = {low_i[Width-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      rem_q    <= rem_d;
      low_q    <= low_d;
      div_q    <= div_i;
      quo_q    <= quo_d;
      status_q <= status_i;
    end
  end

  assign valid_o  = valid_q;
  assign rem_o    = rem_q;
  assign low_o    = low_q;
  assign div_o    = div_q;
  assign quo_o    = quo_q;
  assign status_o = status_q;

endmodule

[hdl/two_word_by_one_word_divider_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_word_by_one_word_divider_top
// divides a two-word dividend by a one-word divisor, quotient and remainder
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i / in_stall_o carries dividend_high_i,
//   dividend_low_i and divisor_i; an item is taken when valid is high and
//   stall is low. output channel out_valid_o / out_stall_i carries
//   quotient_o, remainder_o and status_o (ok, divisor zero, overflow when
//   the high word is at or above the divisor; quotient and remainder are
//   zero on error).
//   a row of WORD_WIDTH cells each does one restoring step and registers it.
//   throughput is one item per cycle while out_stall_i is low. when the
//   receiver stalls the last cell holds its result and stall ripples back
//   only through occupied cells, so empty cells keep taking items until
//   the row is full.
//   reset empties all cells; no result is pending after reset.
// ----------------------------------------------------------------------------
module two_word_by_one_word_divider_top #(
  parameter int unsigned WORD_WIDTH = tbwd_pkg::WordWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [WORD_WIDTH-1:0] dividend_high_i,
  input  logic [WORD_WIDTH-1:0] dividend_low_i,
  input  logic [WORD_WIDTH-1:0] divisor_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [WORD_WIDTH-1:0] quotient_o,
  output logic [WORD_WIDTH-1:0] remainder_o,
  output logic [1:0]            status_o
);
  import tbwd_pkg::*;

  logic                  valid [WORD_WIDTH+1];
  logic                  stall [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] rem   [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] low   [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] div   [WORD_WIDTH+1];
  logic [WORD_WIDTH-1:0] quo   [WORD_WIDTH+1];
  status_e               status [WORD_WIDTH+1];
  status_e               in_status;

  always_comb begin
    if (divisor_i == '0) begin
      in_status = ST_DIV_ZERO;
    end else if (dividend_high_i >= divisor_i) begin
      in_status = ST_OVERFLOW;
    end else begin
      in_status = ST_OK;
    end
  end

  assign valid[0]   = in_valid_i;
  assign in_stall_o = stall[0];
  assign rem[0]     = dividend_high_i;
  assign low[0]     = dividend_low_i;
  assign div[0]     = divisor_i;
  assign quo[0]     = '0;
  assign status[0]  = in_status;

  for (genvar k = 0; k < WORD_WIDTH; k++) begin : g_cell
    tbwd_cell #(
      .Width(WORD_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .stall_o (stall[k]),
      .rem_i   (rem[k]),
      .low_i   (low[k]),
      .div_i   (div[k]),
      .quo_i   (quo[k]),
      .status_i(status[k]),
      .valid_o (valid[k+1]),
      .stall_i (stall[k+1]),
      .rem_o   (rem[k+1]),
      .low_o   (low[k+1]),
      .div_o   (div[k+1]),
      .quo_o   (quo[k+1]),
      .status_o(status[k+1])
    );
  end

  assign stall[WORD_WIDTH] = out_stall_i;
  assign out_valid_o       = valid[WORD_WIDTH];

  // error items run through the row like any other and are zeroed here
  assign quotient_o  = (status[WORD_WIDTH] == ST_OK) ? quo[WORD_WIDTH] : '0;
  assign remainder_o = (status[WORD_WIDTH] == ST_OK) ? rem[WORD_WIDTH] : '0;
  assign status_o    = status[WORD_WIDTH];

`ifndef SYNTHESIS
  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid[WORD_WIDTH] && status[WORD_WIDTH] == ST_OK)
      |-> (rem[WORD_WIDTH] < div[WORD_WIDTH]))
    else $error("remainder not below divisor");

  a_stall_needs_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_drain_frees_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");
`endif

endmodule
